>>> rtl/chet_pkg.sv
// Shared types and constants for the hysteresis edge tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package chet_pkg;

  // Frame and level geometry
  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int MAG_LEVELS = 32768;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int PIXELS = MAX_ROWS * MAX_COLS;
  localparam int PIX_W  = $clog2(PIXELS);
  localparam int CNT_W  = PIX_W + 1;
  localparam int LVL_W  = $clog2(MAG_LEVELS);
  localparam int STK_W  = ROW_W + COL_W;

  // Field widths
  localparam int MAG_W   = 15;
  localparam int DIM_W   = 9;
  localparam int FRAC_W  = 17;
  localparam int FRAC_SH = 16;
  localparam int HIST_W  = CNT_W;
  localparam int PROD_W  = CNT_W + FRAC_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W+1)'(32768);

  // Configuration register indexes
  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_HIFRAC = 2'd2;
  localparam logic [1:0] CFG_LOFRAC = 2'd3;

  // Pixel classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_CAND = 2'd1;
  localparam logic [1:0] CLS_EDGE = 2'd2;

  // Neighbour offsets, walked in order
  localparam logic signed [1:0] NB_DX [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                              -2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] NB_DY [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                              2'sd0, -2'sd1, -2'sd1, -2'sd1};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [MAG_W-1:0]   mag;
    logic               pe;
  } chet_op_t;

  typedef struct packed {
    logic accept_en;
    logic frame_busy;
  } chet_status_t;

endpackage

>>> rtl/canny_hysteresis_edge_tracker_unit.sv
// Top level of the hysteresis edge tracker: front stage, queue, frame engine.
// Depends on chet_pkg, chet_front, chet_queue, chet_back.
//
// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tuser=cmd, tdata={possible_edge, magnitude}
// out_     out  tvalid/tready      tdata={low, high, edge}, tlast=last pixel
// cfg_     in   valid/ready        index, data
//
// Loads and reads both pass a four-entry queue. When the last pixel is loaded the
// engine runs a border and histogram pass over the pixels, a sum pass and a scan
// over the levels, a trace of the in-bound neighbours of every pixel pushed on the
// trace stack, then histogram clearing; input is back-pressured once the queue and
// the input register are full. After reset the histogram is cleared before any item
// is taken. Results wait in an output register while the next read is queued.
`timescale 1ns / 1ps

module canny_hysteresis_edge_tracker_unit
  import chet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] magnitude, [15] possible_edge
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] edge_pixel, [15:1] high_level, [30:16] low_level
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  chet_status_t     status;
  chet_op_t         push_op, q_op;
  logic             q_push, q_full, q_pop, q_valid;
  logic             out_edge;
  logic [MAG_W-1:0] out_high, out_low;

  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, out_low, out_high, out_edge};

  chet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .status    (status),
    .q_push    (q_push),
    .q_op      (push_op),
    .q_full    (q_full)
  );

  chet_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  chet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_edge   (out_edge),
    .out_last   (out_tlast),
    .out_high   (out_high),
    .out_low    (out_low)
  );

endmodule

>>> rtl/chet_front.sv
// Input stage: registers one item, decodes its command and hands it on.
// Depends on chet_pkg.
`timescale 1ns / 1ps

module chet_front
  import chet_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,
  input  logic               in_tuser,
  input  chet_status_t       status,
  output logic               q_push,
  output chet_op_t           q_op,
  input  logic               q_full
);

  logic     hold_v_r, hold_v_nxt;
  chet_op_t hold_r;

  // Forward the held item when the queue has room
  assign q_push    = hold_v_r && !q_full;
  assign q_op      = hold_r;
  assign in_tready = status.accept_en && (!hold_v_r || q_push);

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (q_push) hold_v_nxt = 1'b0;
    if (in_tvalid && in_tready) hold_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  // Classify the command
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r.kind <= in_tuser ? OP_READ : OP_LOAD;
      hold_r.mag  <= in_tdata[MAG_W-1:0];
      hold_r.pe   <= in_tdata[MAG_W];
    end
  end

endmodule

>>> rtl/chet_queue.sv
// Four-entry queue of decoded items between front and back.
// Depends on chet_pkg.
`timescale 1ns / 1ps

module chet_queue
  import chet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  chet_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output chet_op_t q_op
);

  localparam int QD = 4;
  localparam int QP = $clog2(QD);

  chet_op_t        slot_r [QD];
  logic [QP-1:0]   wp_r, rp_r;
  logic [QP:0]     cnt_r, cnt_nxt;

  assign full    = cnt_r == (QP+1)'(QD);
  assign q_valid = cnt_r != '0;
  assign q_op    = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_op;
  end

endmodule

>>> rtl/chet_back.sv
// Frame engine: pixel store, histogram, threshold scan, edge trace, readout.
// Depends on chet_pkg; fed by chet_queue.
`timescale 1ns / 1ps

module chet_back
  import chet_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [FRAC_W-1:0]  cfg_data,
  input  logic               q_valid,
  input  chet_op_t           q_op,
  output logic               q_pop,
  output chet_status_t       status,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_edge,
  output logic               out_last,
  output logic [MAG_W-1:0]   out_high,
  output logic [MAG_W-1:0]   out_low
);

  localparam int NS = 23;

  typedef enum logic [NS-1:0] {
    ST_INIT = NS'(1) << 0,  ST_LOAD = NS'(1) << 1,  ST_BH0  = NS'(1) << 2,
    ST_BH1  = NS'(1) << 3,  ST_BH2  = NS'(1) << 4,  ST_SUM0 = NS'(1) << 5,
    ST_SUM1 = NS'(1) << 6,  ST_HC   = NS'(1) << 7,  ST_SCI  = NS'(1) << 8,
    ST_SCD  = NS'(1) << 9,  ST_SCC  = NS'(1) << 10, ST_LOWM = NS'(1) << 11,
    ST_LOWW = NS'(1) << 12, ST_T0   = NS'(1) << 13, ST_T1   = NS'(1) << 14,
    ST_POP0 = NS'(1) << 15, ST_POP1 = NS'(1) << 16, ST_N0   = NS'(1) << 17,
    ST_N1   = NS'(1) << 18, ST_N2   = NS'(1) << 19, ST_CLR  = NS'(1) << 20,
    ST_RD0  = NS'(1) << 21, ST_RD1  = NS'(1) << 22
  } state_t;

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAG_LEVELS - 1);

  state_t state_r, state_nxt;

  // Configuration and frame registers
  logic [DIM_W-1:0]  rows_cfg_r, cols_cfg_r, frows_r, fcols_r;
  logic [FRAC_W-1:0] hf_r, lf_r;
  logic [CNT_W-1:0]  total_r;
  logic [MAG_W-1:0]  hi_r, lo_r;

  // Working registers
  logic [CNT_W-1:0]  lp_r, rp_r, pos_r, sp_r;
  logic [ROW_W-1:0]  r_r, cr_r;
  logic [COL_W-1:0]  c_r, cc_r;
  logic [LVL_W-1:0]  lvl_r, maxmag_r, mag_l_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W:0]    cum_r;
  logic [PROD_W-1:0] prod_r;
  logic [2:0]        k_r;
  logic [ROW_W+1:0]  nr_r;
  logic [COL_W+1:0]  nc_r;
  logic [PIX_W-1:0]  np_r;

  logic              out_v_r, out_edge_r, out_last_r;
  logic [MAG_W-1:0]  out_hi_r, out_lo_r;

  // Memories
  logic [MAG_W-1:0]  mag_mem [PIXELS];
  logic [1:0]        cls_mem [PIXELS];
  logic [HIST_W-1:0] hist_mem [MAG_LEVELS];
  logic [STK_W-1:0]  stk_mem [PIXELS];

  logic [MAG_W-1:0]  mag_rd_r;
  logic [1:0]        cls_rd_r;
  logic [HIST_W-1:0] hist_rd_r;
  logic [STK_W-1:0]  stk_rd_r;

  logic              mag_we, cls_we, hist_we, stk_we;
  logic [PIX_W-1:0]  pix_ra, pix_wa, stk_ra, stk_wa;
  logic [1:0]        cls_wd;
  logic [LVL_W-1:0]  hist_ra, hist_wa;
  logic [HIST_W-1:0] hist_wd;
  logic [STK_W-1:0]  stk_wd;

  // Combinational helpers
  logic [DIM_W-1:0]   rows_cl, cols_cl;
  logic [2*DIM_W-1:0] total_full;
  logic [CNT_W-1:0]   total_now;
  logic [PROD_W:0]    rnd;
  logic [CNT_W:0]     hc;
  logic               pos_last, is_border, nb_in;
  logic [ROW_W+1:0]   nr_c;
  logic [COL_W+1:0]   nc_c;
  logic [ROW_W+DIM_W-1:0] np_full;
  logic [LVL_W-1:0]   mag_lvl;

  assign rows_cl = (rows_cfg_r < DIM_W'(3)) ? DIM_W'(3) :
                   (rows_cfg_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_cfg_r;
  assign cols_cl = (cols_cfg_r < DIM_W'(3)) ? DIM_W'(3) :
                   (cols_cfg_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_cfg_r;
  assign total_full = rows_cl * cols_cl;
  assign total_now  = total_full[CNT_W-1:0];

  // Rounded Q18.16 product, shared by both threshold steps
  assign rnd = {1'b0, prod_r} + ROUND_HALF;
  assign hc  = rnd[FRAC_SH+CNT_W:FRAC_SH];

  assign pos_last  = pos_r == total_r - 1'b1;
  assign is_border = (r_r == '0) || ({1'b0, r_r} == frows_r - 1'b1) ||
                     (c_r == '0) || ({1'b0, c_r} == fcols_r - 1'b1);

  // Clamp magnitude into the histogram range
  assign mag_lvl = (mag_rd_r > MAG_W'(MAG_LEVELS - 1)) ? LVL_MAX : LVL_W'(mag_rd_r);

  // Neighbour coordinates and bounds
  assign nr_c  = {2'b00, cr_r} - {{ROW_W{NB_DY[k_r][1]}}, NB_DY[k_r]};
  assign nc_c  = {2'b00, cc_r} + {{COL_W{NB_DX[k_r][1]}}, NB_DX[k_r]};
  assign nb_in = !nr_c[ROW_W+1] && !nc_c[COL_W+1] &&
                 (nr_c[ROW_W:0] < frows_r) && (nc_c[COL_W:0] < fcols_r);
  assign np_full = nr_c[ROW_W-1:0] * fcols_r;

  assign status.accept_en  = !state_r[0];
  assign status.frame_busy = !(state_r == ST_LOAD || state_r == ST_RD0 ||
                               state_r == ST_RD1);

  assign out_tvalid = out_v_r;
  assign out_edge   = out_edge_r;
  assign out_last   = out_last_r;
  assign out_high   = out_hi_r;
  assign out_low    = out_lo_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop   = 1'b0;
    mag_we  = 1'b0;
    cls_we  = 1'b0;
    hist_we = 1'b0;
    stk_we  = 1'b0;
    pix_ra  = pos_r[PIX_W-1:0];
    pix_wa  = pos_r[PIX_W-1:0];
    cls_wd  = CLS_NONE;
    hist_ra = lvl_r;
    hist_wa = lvl_r;
    hist_wd = '0;
    stk_ra  = PIX_W'(sp_r - 1'b1);
    stk_wa  = sp_r[PIX_W-1:0];
    stk_wd  = {r_r, c_r};
    unique case (state_r)
      ST_INIT, ST_CLR: begin
        hist_we = 1'b1;
        if (lvl_r == LVL_MAX) state_nxt = (state_r == ST_INIT) ? ST_LOAD : ST_RD0;
      end
      ST_LOAD: begin
        pix_wa = lp_r[PIX_W-1:0];
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op.kind == OP_LOAD) begin
            mag_we = 1'b1;
            cls_we = 1'b1;
            cls_wd = q_op.pe ? CLS_CAND : CLS_NONE;
            if (lp_r + 1'b1 >= total_now) state_nxt = ST_BH0;
          end
        end
      end
      ST_BH0: state_nxt = ST_BH1;
      ST_BH1: begin
        if (is_border) begin
          cls_we = 1'b1;
          cls_wd = CLS_NONE;
        end
        hist_ra = mag_lvl;
        if (!is_border && cls_rd_r == CLS_CAND) state_nxt = ST_BH2;
        else if (pos_last) state_nxt = ST_SUM0;
        else state_nxt = ST_BH0;
      end
      ST_BH2: begin
        hist_we = 1'b1;
        hist_wa = mag_l_r;
        hist_wd = hist_rd_r + 1'b1;
        state_nxt = pos_last ? ST_SUM0 : ST_BH0;
      end
      ST_SUM0: state_nxt = ST_SUM1;
      ST_SUM1: state_nxt = (lvl_r == LVL_MAX) ? ST_HC : ST_SUM0;
      ST_HC:   state_nxt = ST_SCI;
      ST_SCI:  state_nxt = ST_SCD;
      ST_SCD:  state_nxt = ST_SCC;
      ST_SCC: begin
        if (({1'b0, lvl_r} + 1'b1 < {1'b0, maxmag_r}) && (cum_r < hc)) state_nxt = ST_SCI;
        else state_nxt = ST_LOWM;
      end
      ST_LOWM: state_nxt = ST_LOWW;
      ST_LOWW: state_nxt = ST_T0;
      ST_T0:   state_nxt = ST_T1;
      ST_T1: begin
        if (cls_rd_r == CLS_CAND && mag_rd_r >= hi_r) begin
          cls_we = 1'b1;
          cls_wd = CLS_EDGE;
          stk_we = 1'b1;
          stk_wa = '0;
          state_nxt = ST_POP0;
        end else begin
          state_nxt = pos_last ? ST_CLR : ST_T0;
        end
      end
      ST_POP0: begin
        if (sp_r == '0) state_nxt = pos_last ? ST_CLR : ST_T0;
        else state_nxt = ST_POP1;
      end
      ST_POP1: state_nxt = ST_N0;
      ST_N0: begin
        if (nb_in) state_nxt = ST_N1;
        else if (k_r == 3'd7) state_nxt = ST_POP0;
      end
      ST_N1: begin
        pix_ra = np_r;
        state_nxt = ST_N2;
      end
      ST_N2: begin
        pix_wa = np_r;
        stk_wd = {nr_r[ROW_W-1:0], nc_r[COL_W-1:0]};
        if (cls_rd_r == CLS_CAND && mag_rd_r > lo_r) begin
          cls_we = 1'b1;
          cls_wd = CLS_EDGE;
          stk_we = sp_r < CNT_W'(PIXELS);
        end
        state_nxt = (k_r == 3'd7) ? ST_POP0 : ST_N0;
      end
      ST_RD0: begin
        pix_ra = rp_r[PIX_W-1:0];
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op.kind == OP_READ) state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        pix_ra = rp_r[PIX_W-1:0];
        if (!out_v_r || out_tready) begin
          state_nxt = (rp_r + 1'b1 >= total_r) ? ST_LOAD : ST_RD0;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      rows_cfg_r <= DIM_W'(256);
      cols_cfg_r <= DIM_W'(256);
      hf_r       <= FRAC_W'(58982);
      lf_r       <= FRAC_W'(32768);
      lp_r       <= '0;
      rp_r       <= '0;
      hi_r       <= '0;
      lo_r       <= '0;
      lvl_r      <= '0;
      sp_r       <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Take configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROWS:   rows_cfg_r <= cfg_data[DIM_W-1:0];
          CFG_COLS:   cols_cfg_r <= cfg_data[DIM_W-1:0];
          CFG_HIFRAC: hf_r       <= cfg_data;
          CFG_LOFRAC: lf_r       <= cfg_data;
          default:    hf_r       <= hf_r;
        endcase
      end

      if (out_v_r && out_tready) out_v_r <= 1'b0;

      unique case (state_r)
        ST_INIT, ST_CLR: begin
          lvl_r <= lvl_r + 1'b1;
          if (state_r == ST_CLR) rp_r <= '0;
        end
        ST_LOAD: begin
          if (q_valid && q_op.kind == OP_LOAD) begin
            lp_r <= lp_r + 1'b1;
            if (lp_r + 1'b1 >= total_now) begin
              if (hf_r > FRAC_ONE) hf_r <= FRAC_ONE;
              if (lf_r > FRAC_ONE) lf_r <= FRAC_ONE;
            end
          end
        end
        ST_BH1, ST_BH2: begin
          lvl_r <= LVL_W'(1);
        end
        ST_SUM1: lvl_r <= lvl_r + 1'b1;
        ST_HC:   lvl_r <= LVL_W'(1);
        ST_SCC: begin
          if (state_nxt == ST_SCI) lvl_r <= lvl_r + 1'b1;
          else hi_r <= MAG_W'(lvl_r);
        end
        ST_LOWW: begin
          lo_r <= rnd[FRAC_SH+MAG_W-1:FRAC_SH];
          lvl_r <= '0;
        end
        ST_T1: if (state_nxt == ST_POP0) sp_r <= CNT_W'(1);
        ST_POP0: if (sp_r != '0) sp_r <= sp_r - 1'b1;
        ST_N2: if (stk_we) sp_r <= sp_r + 1'b1;
        ST_RD1: begin
          if (!out_v_r || out_tready) begin
            out_v_r <= 1'b1;
            rp_r    <= rp_r + 1'b1;
            if (rp_r + 1'b1 >= total_r) begin
              lp_r <= '0;
              rp_r <= '0;
            end
          end
        end
        default: sp_r <= sp_r;
      endcase
      if (state_r == ST_T1 || state_r == ST_POP0) begin
        if (state_nxt == ST_CLR) lvl_r <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_LOAD: begin
        if (q_valid && q_op.kind == OP_LOAD && lp_r + 1'b1 >= total_now) begin
          frows_r <= rows_cl;
          fcols_r <= cols_cl;
          total_r <= total_now;
          pos_r   <= '0;
          r_r     <= '0;
          c_r     <= '0;
          n_r     <= '0;
          maxmag_r <= '0;
        end
      end
      ST_BH1: begin
        mag_l_r <= mag_lvl;
      end
      ST_SUM1: begin
        if (hist_rd_r != '0) maxmag_r <= lvl_r;
        n_r <= n_r + hist_rd_r;
      end
      ST_HC: begin
        prod_r <= n_r * hf_r;
        cum_r  <= '0;
      end
      ST_SCD:  cum_r  <= cum_r + hist_rd_r;
      ST_LOWM: prod_r <= PROD_W'(hi_r * lf_r);
      ST_LOWW: begin
        pos_r <= '0;
        r_r   <= '0;
        c_r   <= '0;
      end
      ST_POP1: begin
        cr_r <= stk_rd_r[STK_W-1:COL_W];
        cc_r <= stk_rd_r[COL_W-1:0];
        k_r  <= '0;
      end
      ST_N0: begin
        nr_r <= nr_c;
        nc_r <= nc_c;
        np_r <= PIX_W'(np_full + nc_c[COL_W:0]);
        if (!nb_in) k_r <= k_r + 1'b1;
      end
      ST_N2: k_r <= k_r + 1'b1;
      ST_RD1: begin
        if (!out_v_r || out_tready) begin
          out_edge_r <= cls_rd_r == CLS_EDGE;
          out_last_r <= rp_r + 1'b1 >= total_r;
          out_hi_r   <= hi_r;
          out_lo_r   <= lo_r;
        end
      end
      default: k_r <= k_r;
    endcase

    // Advance the raster position at the end of each pixel
    if (((state_r == ST_BH1) && state_nxt != ST_BH2) || (state_r == ST_BH2) ||
        ((state_r == ST_T1) && state_nxt != ST_POP0) ||
        ((state_r == ST_POP0) && sp_r == '0)) begin
      pos_r <= pos_r + 1'b1;
      if ({1'b0, c_r} == fcols_r - 1'b1) begin
        c_r <= '0;
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  // Pixel stores
  always_ff @(posedge clk) begin
    if (mag_we) mag_mem[pix_wa] <= q_op.mag;
    mag_rd_r <= mag_mem[pix_ra];
  end

  always_ff @(posedge clk) begin
    if (cls_we) cls_mem[pix_wa] <= cls_wd;
    cls_rd_r <= cls_mem[pix_ra];
  end

  // Histogram
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[hist_ra];
  end

  // Trace stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(PIXELS))
    else $error("trace stack pointer beyond depth");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_RD1))
    else $error("result raised outside readout");

  a_rd_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD1) |-> (rp_r < total_r))
    else $error("read position past frame end");

endmodule
